// ===== src/tcd_pkg.sv =====
`default_nettype none

package tcd_pkg;

  // Telnet protocol bytes
  localparam logic [7:0] IAC    = 8'd255;
  localparam logic [7:0] DONT   = 8'd254;
  localparam logic [7:0] DO     = 8'd253;
  localparam logic [7:0] WONT   = 8'd252;
  localparam logic [7:0] WILL   = 8'd251;
  localparam logic [7:0] SB     = 8'd250;
  localparam logic [7:0] NOP    = 8'd241;
  localparam logic [7:0] ECHO   = 8'd1;
  localparam logic [7:0] SGA    = 8'd3;
  localparam logic [7:0] WINDOW = 8'd31;
  localparam logic [7:0] SPEED  = 8'd32;

  // Input item kinds
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_OPEN = 1'b1;

  // Result kinds
  localparam logic [1:0] OUT_DATA = 2'd0;
  localparam logic [1:0] OUT_TX   = 2'd1;
  localparam logic [1:0] OUT_WIN  = 2'd2;

  localparam int GreetLen = 15;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } tcd_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] win_width;
    logic [15:0] win_height;
    logic        last;
  } tcd_out_t;

  // Greeting negotiation sent on session open
  function automatic logic [7:0] greeting_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = IAC;
      4'd1:    b = DONT;
      4'd2:    b = ECHO;
      4'd3:    b = IAC;
      4'd4:    b = DO;
      4'd5:    b = WINDOW;
      4'd6:    b = IAC;
      4'd7:    b = DO;
      4'd8:    b = SPEED;
      4'd9:    b = IAC;
      4'd10:   b = WILL;
      4'd11:   b = ECHO;
      4'd12:   b = IAC;
      4'd13:   b = WILL;
      4'd14:   b = SGA;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/telnet_command_deframer_core.sv =====
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o | tcd_in_t  (kind, value)
// out     | output    | out_valid_o/out_stall_i | tcd_out_t (out_kind .. last)
//
// One request per cycle enters the input register while in_stall_o is low, and
// is parsed as it moves on. A request causes one result or none; a NOP reply is
// two results, a DONT reply three and the session-open greeting 15 results.
// Reset clears the parser phase, counters and both valid flags at once.
// Output stall holds the burst register; the input register still takes one
// more request, then input stall rises until the burst drains.
module telnet_command_deframer_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire tcd_pkg::tcd_in_t in_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output tcd_pkg::tcd_out_t     out_o
);

  // Parser phases
  localparam logic [2:0] PH_DATA     = 3'd0;
  localparam logic [2:0] PH_IAC      = 3'd1;
  localparam logic [2:0] PH_NEGO     = 3'd2;
  localparam logic [2:0] PH_SB_OPT   = 3'd3;
  localparam logic [2:0] PH_SB_FIRST = 3'd4;
  localparam logic [2:0] PH_SB_BODY  = 3'd5;
  localparam logic [2:0] PH_SB_END   = 3'd6;

  // Burst types
  localparam logic [2:0] BU_DATA  = 3'd0;
  localparam logic [2:0] BU_NOP   = 3'd1;
  localparam logic [2:0] BU_DONT  = 3'd2;
  localparam logic [2:0] BU_WIN   = 3'd3;
  localparam logic [2:0] BU_GREET = 3'd4;

  logic              in_valid_q, in_valid_d;
  tcd_pkg::tcd_in_t  in_item_q;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  option_q, option_d;
  logic [7:0]  command_q, command_d;
  logic [2:0]  count_q, count_d;
  logic [7:0]  payload_q [4];

  logic        burst_valid_q, burst_valid_d;
  logic [2:0]  burst_kind_q, burst_kind_d;
  logic [3:0]  burst_idx_q, burst_idx_d;
  logic [7:0]  burst_byte_q, burst_byte_d;
  logic [31:0] burst_win_q, burst_win_d;

  logic        emit;
  logic [2:0]  emit_kind;
  logic [7:0]  emit_byte;
  logic [31:0] emit_win;
  logic        take;

  logic [3:0]  burst_len;
  logic        burst_last;
  logic        out_fire;
  logic        move;
  logic        in_accept;

  // Burst length and last beat
  always_comb begin
    case (burst_kind_q)
      BU_NOP:   burst_len = 4'd2;
      BU_DONT:  burst_len = 4'd3;
      BU_GREET: burst_len = 4'(tcd_pkg::GreetLen);
      default:  burst_len = 4'd1;
    endcase
  end

  assign burst_last  = (burst_idx_q == burst_len - 4'd1);
  assign out_valid_o = burst_valid_q;
  assign out_fire    = burst_valid_q && !out_stall_i;
  assign move        = in_valid_q && (!burst_valid_q || (out_fire && burst_last));
  assign in_stall_o  = in_valid_q && !move;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (move) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_i;
    end
  end

  // Parse the held request
  always_comb begin
    phase_d   = phase_q;
    option_d  = option_q;
    command_d = command_q;
    count_d   = count_q;
    emit      = 1'b0;
    emit_kind = BU_DATA;
    emit_byte = in_item_q.value;
    emit_win  = 32'd0;
    take      = 1'b0;
    if (in_item_q.kind == tcd_pkg::IN_OPEN) begin
      phase_d   = PH_DATA;
      option_d  = 8'd0;
      command_d = 8'd0;
      count_d   = 3'd0;
      emit      = 1'b1;
      emit_kind = BU_GREET;
    end else begin
      case (phase_q)
        PH_IAC: begin
          if (in_item_q.value == tcd_pkg::WILL || in_item_q.value == tcd_pkg::WONT ||
              in_item_q.value == tcd_pkg::DO || in_item_q.value == tcd_pkg::DONT) begin
            command_d = in_item_q.value;
            phase_d   = PH_NEGO;
          end else if (in_item_q.value == tcd_pkg::SB) begin
            phase_d = PH_SB_OPT;
          end else begin
            if (in_item_q.value == tcd_pkg::NOP) begin
              emit      = 1'b1;
              emit_kind = BU_NOP;
            end
            phase_d = PH_DATA;
          end
        end
        PH_NEGO: begin
          option_d = in_item_q.value;
          if (command_q == tcd_pkg::DONT) begin
            emit      = 1'b1;
            emit_kind = BU_DONT;
          end
          phase_d = PH_DATA;
        end
        PH_SB_OPT: begin
          option_d = in_item_q.value;
          count_d  = 3'd0;
          phase_d  = PH_SB_FIRST;
        end
        PH_SB_FIRST: begin
          take    = 1'b1;
          phase_d = PH_SB_BODY;
        end
        PH_SB_BODY: begin
          if (in_item_q.value == tcd_pkg::IAC) begin
            phase_d = PH_SB_END;
          end else begin
            take = 1'b1;
          end
        end
        PH_SB_END: begin
          if (option_q == tcd_pkg::WINDOW && count_q[2]) begin
            emit      = 1'b1;
            emit_kind = BU_WIN;
            emit_win  = {payload_q[0], payload_q[1], payload_q[2], payload_q[3]};
          end
          phase_d = PH_DATA;
        end
        default: begin
          if (in_item_q.value == tcd_pkg::IAC) begin
            phase_d = PH_IAC;
          end else begin
            emit      = 1'b1;
            emit_kind = BU_DATA;
            phase_d   = PH_DATA;
          end
        end
      endcase
    end
    // Count payload bytes, saturating at four
    if (take && !count_q[2]) begin
      count_d = count_q + 3'd1;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_DATA;
      option_q  <= 8'd0;
      command_q <= 8'd0;
      count_q   <= 3'd0;
    end else if (move) begin
      phase_q   <= phase_d;
      option_q  <= option_d;
      command_q <= command_d;
      count_q   <= count_d;
    end
  end

  // Store the first four payload bytes
  always_ff @(posedge clk_i) begin
    if (move && take && !count_q[2]) begin
      payload_q[count_q[1:0]] <= in_item_q.value;
    end
  end

  // Burst register: load on move, advance on each taken result
  always_comb begin
    burst_valid_d = burst_valid_q;
    burst_kind_d  = burst_kind_q;
    burst_idx_d   = burst_idx_q;
    burst_byte_d  = burst_byte_q;
    burst_win_d   = burst_win_q;
    if (move) begin
      burst_valid_d = emit;
      burst_kind_d  = emit_kind;
      burst_idx_d   = 4'd0;
      burst_byte_d  = emit_byte;
      burst_win_d   = emit_win;
    end else if (out_fire) begin
      if (burst_last) begin
        burst_valid_d = 1'b0;
      end else begin
        burst_idx_d = burst_idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_valid_q <= 1'b0;
      burst_idx_q   <= 4'd0;
    end else begin
      burst_valid_q <= burst_valid_d;
      burst_idx_q   <= burst_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    burst_kind_q <= burst_kind_d;
    burst_byte_q <= burst_byte_d;
    burst_win_q  <= burst_win_d;
  end

  // Form the current result
  always_comb begin
    out_o.out_kind   = tcd_pkg::OUT_TX;
    out_o.out_byte   = 8'd0;
    out_o.win_width  = 16'd0;
    out_o.win_height = 16'd0;
    out_o.last       = burst_last;
    case (burst_kind_q)
      BU_DATA: begin
        out_o.out_kind = tcd_pkg::OUT_DATA;
        out_o.out_byte = burst_byte_q;
      end
      BU_NOP: begin
        out_o.out_byte = (burst_idx_q == 4'd0) ? tcd_pkg::IAC : tcd_pkg::NOP;
      end
      BU_DONT: begin
        case (burst_idx_q)
          4'd0:    out_o.out_byte = tcd_pkg::IAC;
          4'd1:    out_o.out_byte = tcd_pkg::WONT;
          default: out_o.out_byte = burst_byte_q;
        endcase
      end
      BU_WIN: begin
        out_o.out_kind   = tcd_pkg::OUT_WIN;
        out_o.win_width  = burst_win_q[31:16];
        out_o.win_height = burst_win_q[15:0];
      end
      default: begin
        out_o.out_byte = tcd_pkg::greeting_byte(burst_idx_q);
      end
    endcase
  end

  // Checks
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_valid_q |-> (burst_idx_q < burst_len))
    else $error("burst index past burst length");

  a_held_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !move) |=> in_valid_q)
    else $error("held request dropped");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && burst_last && !in_valid_q) |=> !burst_valid_q)
    else $error("burst not emptied after last result");

  a_win_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.out_kind == tcd_pkg::OUT_WIN) |-> out_o.last)
    else $error("window report not marked last");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("payload count above four");

endmodule

`default_nettype wire

// ===== verif/tcd_checker.sv =====
module tcd_checker (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  tcd_pkg::tcd_in_t  in_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  tcd_pkg::tcd_out_t out_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_DATA,
    ST_IAC,
    ST_NEGO,
    ST_SB_OPT,
    ST_SB_FIRST,
    ST_SB_BODY,
    ST_SB_END
  } parse_state_e;

  // Greeting bytes, first byte in the top lane
  localparam logic [8*tcd_pkg::GreetLen-1:0] GreetingBytes = {
    tcd_pkg::IAC, tcd_pkg::DONT, tcd_pkg::ECHO,
    tcd_pkg::IAC, tcd_pkg::DO, tcd_pkg::WINDOW,
    tcd_pkg::IAC, tcd_pkg::DO, tcd_pkg::SPEED,
    tcd_pkg::IAC, tcd_pkg::WILL, tcd_pkg::ECHO,
    tcd_pkg::IAC, tcd_pkg::WILL, tcd_pkg::SGA
  };

  parse_state_e      state;
  logic [7:0]        opt_code;
  logic [7:0]        cmd_code;
  logic [2:0]        pay_cnt;
  logic [7:0]        pay_bytes [4];
  tcd_pkg::tcd_out_t expected_results [$];
  tcd_pkg::tcd_out_t head_result;
  int                errors;

  function automatic void push_result(logic [1:0] kind, logic [7:0] b, logic [15:0] w,
                                      logic [15:0] h, logic fin);
    tcd_pkg::tcd_out_t r;
    r.out_kind   = kind;
    r.out_byte   = b;
    r.win_width  = w;
    r.win_height = h;
    r.last       = fin;
    expected_results.push_back(r);
  endfunction

  // Keep the first four payload bytes, drop the rest
  function automatic void store_payload(logic [7:0] b);
    if (pay_cnt < 3'd4) begin
      pay_bytes[pay_cnt[1:0]] = b;
      pay_cnt = pay_cnt + 3'd1;
    end
  endfunction

  // Advance the parser by one request and queue the results it causes
  function automatic void deframe_request(tcd_pkg::tcd_in_t req);
    logic [7:0] b;
    int         i;
    b = req.value;
    if (req.kind == tcd_pkg::IN_OPEN) begin
      state    = ST_DATA;
      opt_code = '0;
      cmd_code = '0;
      pay_cnt  = '0;
      for (i = 0; i < tcd_pkg::GreetLen; i++) begin
        push_result(tcd_pkg::OUT_TX, GreetingBytes[8*(tcd_pkg::GreetLen-1-i) +: 8], '0, '0,
                    i == tcd_pkg::GreetLen - 1);
      end
    end else begin
      case (state)
        ST_IAC: begin
          if (b == tcd_pkg::WILL || b == tcd_pkg::WONT || b == tcd_pkg::DO ||
              b == tcd_pkg::DONT) begin
            cmd_code = b;
            state    = ST_NEGO;
          end else if (b == tcd_pkg::SB) begin
            state = ST_SB_OPT;
          end else begin
            if (b == tcd_pkg::NOP) begin
              push_result(tcd_pkg::OUT_TX, tcd_pkg::IAC, '0, '0, 1'b0);
              push_result(tcd_pkg::OUT_TX, tcd_pkg::NOP, '0, '0, 1'b1);
            end
            state = ST_DATA;
          end
        end
        ST_NEGO: begin
          opt_code = b;
          if (cmd_code == tcd_pkg::DONT) begin
            push_result(tcd_pkg::OUT_TX, tcd_pkg::IAC, '0, '0, 1'b0);
            push_result(tcd_pkg::OUT_TX, tcd_pkg::WONT, '0, '0, 1'b0);
            push_result(tcd_pkg::OUT_TX, b, '0, '0, 1'b1);
          end
          state = ST_DATA;
        end
        ST_SB_OPT: begin
          opt_code = b;
          pay_cnt  = '0;
          state    = ST_SB_FIRST;
        end
        // first payload byte is taken even when it is IAC
        ST_SB_FIRST: begin
          store_payload(b);
          state = ST_SB_BODY;
        end
        ST_SB_BODY: begin
          if (b == tcd_pkg::IAC) begin
            state = ST_SB_END;
          end else begin
            store_payload(b);
          end
        end
        ST_SB_END: begin
          if (opt_code == tcd_pkg::WINDOW && pay_cnt >= 3'd4) begin
            push_result(tcd_pkg::OUT_WIN, '0, {pay_bytes[0], pay_bytes[1]},
                        {pay_bytes[2], pay_bytes[3]}, 1'b1);
          end
          state = ST_DATA;
        end
        default: begin
          if (b == tcd_pkg::IAC) begin
            state = ST_IAC;
          end else begin
            push_result(tcd_pkg::OUT_DATA, b, '0, '0, 1'b1);
            state = ST_DATA;
          end
        end
      endcase
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state    = ST_DATA;
      opt_code = '0;
      cmd_code = '0;
      pay_cnt  = '0;
      expected_results.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        deframe_request(in_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_kind %0d out_byte %0h", out_i.out_kind,
                 out_i.out_byte);
          errors++;
        end else begin
          head_result = expected_results.pop_front();
          check_field("out_kind", 16'(head_result.out_kind), 16'(out_i.out_kind));
          check_field("out_byte", 16'(head_result.out_byte), 16'(out_i.out_byte));
          check_field("win_width", head_result.win_width, out_i.win_width);
          check_field("win_height", head_result.win_height, out_i.win_height);
          check_field("last", 16'(head_result.last), 16'(out_i.last));
        end
      end
      pending_o    <= expected_results.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== verif/tb_telnet_command_deframer_core.sv =====
module tb_telnet_command_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalItems  = 110;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  tcd_pkg::tcd_in_t  in_req;
  logic              out_valid;
  logic              out_stall;
  tcd_pkg::tcd_out_t out_rsp;
  int                fail_count;
  int                pending;
  logic              calm;
  int                stall_left;
  int                idle_cycles;
  int                items_sent;

  telnet_command_deframer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_rsp)
  );

  tcd_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Stall the result side in random bursts unless in a calm stretch
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb_telnet_command_deframer_core: errors");
      $finish;
    end
  end

  // Hold one request until it is accepted, after an optional gap
  task automatic send_request(input tcd_pkg::tcd_in_t req);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    tcd_pkg::tcd_in_t req;
    req.kind  = tcd_pkg::IN_BYTE;
    req.value = b;
    send_request(req);
  endtask

  task automatic send_open(input logic [7:0] b);
    tcd_pkg::tcd_in_t req;
    req.kind  = tcd_pkg::IN_OPEN;
    req.value = b;
    send_request(req);
  endtask

  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 4))
      0:       return tcd_pkg::ECHO;
      1:       return tcd_pkg::SGA;
      2:       return tcd_pkg::WINDOW;
      3:       return tcd_pkg::SPEED;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_negotiation();
    case ($urandom_range(0, 3))
      0:       return tcd_pkg::WILL;
      1:       return tcd_pkg::WONT;
      2:       return tcd_pkg::DO;
      default: return tcd_pkg::DONT;
    endcase
  endfunction

  // Send one random command sequence, mostly well formed
  task automatic send_random_sequence();
    int pick;
    int n;
    int i;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      send_byte(8'($urandom_range(0, 254)));
    end else if (pick < 48) begin
      send_byte(tcd_pkg::IAC);
      send_byte(pick_negotiation());
      send_byte(pick_option());
    end else if (pick < 54) begin
      send_byte(tcd_pkg::IAC);
      send_byte(tcd_pkg::NOP);
    end else if (pick < 60) begin
      send_byte(tcd_pkg::IAC);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      // subnegotiation, some cut short
      n   = $urandom_range(0, 9);
      n   = (n < 5) ? 4 : (n < 8) ? $urandom_range(1, 3) : $urandom_range(5, 7);
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : -1;
      send_byte(tcd_pkg::IAC);
      send_byte(tcd_pkg::SB);
      send_byte(($urandom_range(0, 3) == 0) ? pick_option() : tcd_pkg::WINDOW);
      for (i = 0; i < n; i++) begin
        if (i == cut) return;
        send_byte((i == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 254)));
      end
      send_byte(tcd_pkg::IAC);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      send_open(8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_req     = '0;
    out_stall  = 1'b0;
    calm       = 1'b0;
    stall_left = 0;
    items_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // greeting, then plain data at both ends of the range
    send_open(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFE);
    // NOP and DONT replies, doubled IAC dropped
    send_byte(tcd_pkg::IAC);
    send_byte(tcd_pkg::NOP);
    send_byte(tcd_pkg::IAC);
    send_byte(tcd_pkg::DONT);
    send_byte(tcd_pkg::ECHO);
    send_byte(tcd_pkg::IAC);
    send_byte(tcd_pkg::IAC);
    // window payload led by IAC, one byte past four dropped
    send_byte(tcd_pkg::IAC);
    send_byte(tcd_pkg::SB);
    send_byte(tcd_pkg::WINDOW);
    send_byte(tcd_pkg::IAC);
    send_byte(8'h50);
    send_byte(8'h00);
    send_byte(8'h18);
    send_byte(8'h7F);
    send_byte(tcd_pkg::IAC);
    send_byte(8'hF0);
    // short window payload gives no report
    send_byte(tcd_pkg::IAC);
    send_byte(tcd_pkg::SB);
    send_byte(tcd_pkg::WINDOW);
    send_byte(8'h01);
    send_byte(tcd_pkg::IAC);
    send_byte(8'hF0);
    // session open abandons a half-parsed subnegotiation
    send_byte(tcd_pkg::IAC);
    send_byte(tcd_pkg::SB);
    send_open(8'h00);

    while (items_sent < TotalItems) begin
      if ($urandom_range(0, 11) == 0) calm <= ~calm;
      send_random_sequence();
    end

    // drain outstanding results
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_telnet_command_deframer_core: clean");
    end else begin
      $display("tb_telnet_command_deframer_core: errors");
    end
    $finish;
  end

endmodule
